### rtl/bosd_pkg.sv
`default_nettype none

package bosd_pkg;

  // Stream and record sizing.
  localparam int unsigned MaxRecords = 8192;
  localparam int unsigned OffsetBits = 24;
  localparam int unsigned RecIdxW    = 13;
  localparam int unsigned RecCntW    = 14;
  localparam int unsigned LebShiftW  = 7;

  // LEB128 operands stop contributing once the shift reaches one word.
  localparam logic [LebShiftW-1:0] LebShiftLimit = 7'd64;
  localparam logic [LebShiftW-1:0] LebShiftStep  = 7'd7;

  // Address stride applied by every bind opcode.
  localparam logic [63:0] BindStride = 64'd8;

  // Decoder phase codes.
  localparam logic [2:0] PhOpcode    = 3'd0;
  localparam logic [2:0] PhDone      = 3'd1;
  localparam logic [2:0] PhOrdLeb    = 3'd2;
  localparam logic [2:0] PhAddendLeb = 3'd3;
  localparam logic [2:0] PhAddrLeb   = 3'd4;
  localparam logic [2:0] PhSkipName  = 3'd5;

  // High-nibble opcodes of the binding stream.
  typedef enum logic [3:0] {
    OpDone       = 4'h0,
    OpSetOrdImm  = 4'h1,
    OpSetOrdUleb = 4'h2,
    OpSetSymbol  = 4'h4,
    OpSetType    = 4'h5,
    OpSetAddend  = 4'h6,
    OpSetAddr    = 4'h7,
    OpBind       = 4'h9
  } opcode_e;

  typedef struct packed {
    logic [2:0]            phase;
    logic [63:0]           leb_acc;
    logic [LebShiftW-1:0]  leb_shift;
    logic [31:0]           ordinal;
    logic [3:0]            bind_kind;
    logic [63:0]           addend;
    logic [63:0]           address;
    logic [OffsetBits-1:0] sym_offset;
    logic                  sym_seen;
    logic [OffsetBits-1:0] byte_pos;
    logic [RecCntW-1:0]    rec_count;
  } state_t;

  typedef struct packed {
    logic [31:0]           ordinal;
    logic [3:0]            bind_kind;
    logic [63:0]           addend;
    logic [63:0]           address;
    logic [OffsetBits-1:0] name_offset;
    logic                  name_valid;
    logic [RecIdxW-1:0]    index;
  } record_t;

endpackage

`default_nettype wire

### rtl/bosd_step.sv
`default_nettype none

module bosd_step (
  input  bosd_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output bosd_pkg::state_t  state_o,
  output logic              emit_o,
  output bosd_pkg::record_t record_o
);
  import bosd_pkg::*;

  logic [63:0]          leb_bits;
  logic [63:0]          leb_acc_new;
  logic [LebShiftW-1:0] leb_shift_new;
  logic [63:0]          sleb_value;

  // Operand byte folded into the accumulator, unless the shift has saturated.
  always_comb begin
    leb_bits      = 64'(data_byte_i[6:0]) << state_i.leb_shift[5:0];
    leb_acc_new   = state_i.leb_acc;
    leb_shift_new = state_i.leb_shift;
    if (state_i.leb_shift < LebShiftLimit) begin
      leb_acc_new   = state_i.leb_acc | leb_bits;
      leb_shift_new = state_i.leb_shift + LebShiftStep;
    end
    sleb_value = leb_acc_new;
    if ((leb_shift_new < LebShiftLimit) && data_byte_i[6]) begin
      sleb_value = leb_acc_new | ({64{1'b1}} << leb_shift_new[5:0]);
    end
  end

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;

    record_o.ordinal     = state_i.ordinal;
    record_o.bind_kind   = state_i.bind_kind;
    record_o.addend      = state_i.addend;
    record_o.address     = state_i.address;
    record_o.name_offset = state_i.sym_offset;
    record_o.name_valid  = state_i.sym_seen;
    record_o.index       = state_i.rec_count[RecIdxW-1:0];

    case (state_i.phase)
      PhOpcode: begin
        case (opcode_e'(data_byte_i[7:4]))
          OpDone:       state_o.phase = PhDone;
          OpSetOrdImm:  state_o.ordinal = 32'(data_byte_i[3:0]);
          OpSetOrdUleb: begin
            state_o.leb_acc   = '0;
            state_o.leb_shift = '0;
            state_o.phase     = PhOrdLeb;
          end
          OpSetSymbol: begin
            state_o.sym_offset = state_i.byte_pos + OffsetBits'(1);
            state_o.sym_seen   = 1'b1;
            state_o.phase      = PhSkipName;
          end
          OpSetType:    state_o.bind_kind = data_byte_i[3:0];
          OpSetAddend: begin
            state_o.leb_acc   = '0;
            state_o.leb_shift = '0;
            state_o.phase     = PhAddendLeb;
          end
          OpSetAddr: begin
            state_o.leb_acc   = '0;
            state_o.leb_shift = '0;
            state_o.phase     = PhAddrLeb;
          end
          OpBind: begin
            if (state_i.rec_count < RecCntW'(MaxRecords)) begin
              emit_o            = 1'b1;
              state_o.rec_count = state_i.rec_count + RecCntW'(1);
            end
            state_o.address = state_i.address + BindStride;
          end
          default: ;
        endcase
      end
      PhOrdLeb, PhAddendLeb, PhAddrLeb: begin
        state_o.leb_acc   = leb_acc_new;
        state_o.leb_shift = leb_shift_new;
        if (!data_byte_i[7]) begin
          case (state_i.phase)
            PhOrdLeb:    state_o.ordinal = leb_acc_new[31:0];
            PhAddrLeb:   state_o.address = leb_acc_new;
            default:     state_o.addend  = sleb_value;
          endcase
          state_o.phase = PhOpcode;
        end
      end
      PhSkipName: begin
        if (data_byte_i == 8'h00) begin
          state_o.phase = PhOpcode;
        end
      end
      default: ;
    endcase

    state_o.byte_pos = state_i.byte_pos + OffsetBits'(1);

    // The final byte of a stream returns everything to the reset state.
    if (end_of_stream_i) begin
      state_o       = '0;
      state_o.phase = PhOpcode;
    end
  end

endmodule

`default_nettype wire

### rtl/bind_opcode_stream_decoder_unit.sv
// A bind byte waits in the input register until the result register is free, then its record moves there.
// Throughput: one stream byte per cycle, except while a waiting record stalls the input.
// A waiting record only stalls the input when the next byte would also produce a record.
// Reset (rst_ni low, asynchronous) clears the decoder state, the record count and both valids.
// The byte flagged end_of_stream also returns the decoder state to its reset value.
`default_nettype none

module bind_opcode_stream_decoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                end_of_stream_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  lib_ordinal_o,
  output logic [3:0]                          bind_kind_o,
  output logic signed [63:0]                  addend_o,
  output logic [63:0]                         bind_address_o,
  output logic [bosd_pkg::OffsetBits-1:0]     name_offset_o,
  output logic                                name_valid_o,
  output logic [bosd_pkg::RecIdxW-1:0]        record_index_o
);
  import bosd_pkg::*;

  // Input register: one request of the byte stream waits here to be decoded.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;

  // Decoder state, updated once per decoded byte.
  state_t state_q;
  state_t state_d;

  // Result register holding one finished bind record.
  logic    out_valid_q;
  record_t out_rec_q;

  logic    step_emit;
  record_t step_rec;
  logic    advance;

  bosd_step u_step (
    .state_i         (state_q),
    .data_byte_i     (in_byte_q),
    .end_of_stream_i (in_eos_q),
    .state_o         (state_d),
    .emit_o          (step_emit),
    .record_o        (step_rec)
  );

  // A byte that makes no record can always move on. A byte that makes one
  // needs the result register empty or emptying in this cycle.
  assign advance    = in_valid_q && (!step_emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && step_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_eos_q  <= end_of_stream_i;
    end
    if (advance && step_emit) begin
      out_rec_q <= step_rec;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign lib_ordinal_o     = out_rec_q.ordinal;
  assign bind_kind_o       = out_rec_q.bind_kind;
  assign addend_o          = out_rec_q.addend;
  assign bind_address_o    = out_rec_q.address;
  assign name_offset_o     = out_rec_q.name_offset;
  assign name_valid_o      = out_rec_q.name_valid;
  assign record_index_o    = out_rec_q.index;

endmodule

`default_nettype wire

### rtl/bosd_checker.sv
`default_nettype none

module bosd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [63:0]                         bind_address_o,
  input logic [bosd_pkg::OffsetBits-1:0]     name_offset_o,
  input logic                                name_valid_o,
  input logic [bosd_pkg::RecIdxW-1:0]        record_index_o
);
  import bosd_pkg::*;

  logic               seen_q;
  logic [RecIdxW-1:0] last_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      seen_q     <= 1'b1;
      last_idx_q <= record_index_o;
    end
  end

  // A byte request that is not taken stays offered.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("byte request withdrawn while stalled");

  // A record that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("record dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(bind_address_o) && $stable(record_index_o))
    else $error("stalled record changed");

  // Without a symbol opcode the name offset is empty.
  a_name_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !name_valid_o |-> name_offset_o == '0)
    else $error("name offset set without a symbol");

  // Records are numbered in sequence; an index of zero, as at the start of a new stream, is always accepted.
  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && seen_q |->
      record_index_o == last_idx_q + RecIdxW'(1) || record_index_o == '0)
    else $error("record index out of sequence");

endmodule

bind bind_opcode_stream_decoder_unit bosd_checker u_bosd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .bind_address_o (bind_address_o),
  .name_offset_o  (name_offset_o),
  .name_valid_o   (name_valid_o),
  .record_index_o (record_index_o)
);

`default_nettype wire
